@@ hw/rtl/ivalu_pkg.sv @@
// shared types, opcodes and helpers for the 2d integer vector alu
package ivalu_pkg;

  localparam int CW      = 32;        // component width
  localparam int FW      = 32;        // port field width
  localparam int SQ_RW   = CW + 2;    // square root partial remainder width

  typedef logic signed [CW-1:0] comp_t;
  typedef logic [CW-1:0]        mag_t;
  typedef logic [2*CW-1:0]      rad_t;

  typedef enum logic [3:0] {
    OP_ADD  = 4'd0,
    OP_SUB  = 4'd1,
    OP_MUL  = 4'd2,
    OP_ADDS = 4'd3,
    OP_SUBS = 4'd4,
    OP_MULS = 4'd5,
    OP_DIVS = 4'd6,
    OP_EQ   = 4'd7,
    OP_NE   = 4'd8,
    OP_DOT  = 4'd9,
    OP_MAG  = 4'd10,
    OP_NORM = 4'd11,
    OP_PROJ = 4'd12
  } op_t;

  // context that travels with every word through the pipeline
  typedef struct packed {
    logic [3:0] op;
    comp_t      ax;
    comp_t      ay;
    comp_t      bx;
    comp_t      by;
    comp_t      s;
    comp_t      dot;
    comp_t      rx;
    comp_t      ry;
    comp_t      rs;
    logic       cmp;
    logic       flag;   // zero divisor, or zero magnitude for normalize
    logic       neg_x;
    logic       neg_y;
  } ctx_t;

  function automatic mag_t abs_c(comp_t v);
    return v[CW-1] ? mag_t'(-v) : mag_t'(v);
  endfunction

endpackage

@@ hw/rtl/ivalu_sqrt.sv @@
// pipelined integer square root, one result bit per stage
module ivalu_sqrt (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_valid,
  input  ivalu_pkg::rad_t in_rad,
  input  ivalu_pkg::ctx_t in_ctx,
  output logic            out_valid,
  output ivalu_pkg::mag_t out_root,
  output ivalu_pkg::ctx_t out_ctx
);
  import ivalu_pkg::*;

  logic [SQ_RW-1:0] rem_r  [1:CW];
  mag_t             root_r [1:CW];
  rad_t             rad_r  [1:CW];
  ctx_t             ctx_r  [1:CW];
  logic             vld_r  [1:CW];

  logic [SQ_RW-1:0] rem_s  [0:CW-1];
  mag_t             root_s [0:CW-1];
  rad_t             rad_s  [0:CW-1];
  ctx_t             ctx_s  [0:CW-1];
  logic             vld_s  [0:CW-1];

  assign rem_s[0]  = '0;
  assign root_s[0] = '0;
  assign rad_s[0]  = in_rad;
  assign ctx_s[0]  = in_ctx;
  assign vld_s[0]  = in_valid;

  genvar g;
  generate
    for (g = 0; g < CW; g++) begin : g_stage
      logic [SQ_RW+1:0] t;
      logic [SQ_RW+1:0] trial;
      logic             ge;
      logic [SQ_RW-1:0] rem_nxt;
      mag_t             root_nxt;

      if (g > 0) begin : g_link
        assign rem_s[g]  = rem_r[g];
        assign root_s[g] = root_r[g];
        assign rad_s[g]  = rad_r[g];
        assign ctx_s[g]  = ctx_r[g];
        assign vld_s[g]  = vld_r[g];
      end

      always_comb begin
        t        = {rem_s[g], rad_s[g][2*CW-1 -: 2]};
        trial    = {2'b00, root_s[g], 2'b01};
        ge       = (t >= trial);
        rem_nxt  = ge ? SQ_RW'(t - trial) : SQ_RW'(t);
        root_nxt = {root_s[g][CW-2:0], ge};
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r[g+1] <= 1'b0;
        end else if (en) begin
          vld_r[g+1] <= vld_s[g];
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[g+1]  <= rem_nxt;
          root_r[g+1] <= root_nxt;
          rad_r[g+1]  <= {rad_s[g][2*CW-3:0], 2'b00};
          ctx_r[g+1]  <= ctx_s[g];
        end
      end
    end
  endgenerate

  assign out_valid = vld_r[CW];
  assign out_root  = root_r[CW];
  assign out_ctx   = ctx_r[CW];

endmodule

@@ hw/rtl/ivalu_div.sv @@
// pipelined two-lane unsigned restoring divider with a shared divisor
module ivalu_div (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_valid,
  input  ivalu_pkg::mag_t in_num_x,
  input  ivalu_pkg::mag_t in_num_y,
  input  ivalu_pkg::mag_t in_den,
  input  ivalu_pkg::ctx_t in_ctx,
  output logic            out_valid,
  output ivalu_pkg::mag_t out_q_x,
  output ivalu_pkg::mag_t out_q_y,
  output ivalu_pkg::ctx_t out_ctx
);
  import ivalu_pkg::*;

  mag_t remx_r [1:CW];
  mag_t remy_r [1:CW];
  mag_t nqx_r  [1:CW];
  mag_t nqy_r  [1:CW];
  mag_t den_r  [1:CW];
  ctx_t ctx_r  [1:CW];
  logic vld_r  [1:CW];

  mag_t remx_s [0:CW-1];
  mag_t remy_s [0:CW-1];
  mag_t nqx_s  [0:CW-1];
  mag_t nqy_s  [0:CW-1];
  mag_t den_s  [0:CW-1];
  ctx_t ctx_s  [0:CW-1];
  logic vld_s  [0:CW-1];

  assign remx_s[0] = '0;
  assign remy_s[0] = '0;
  assign nqx_s[0]  = in_num_x;
  assign nqy_s[0]  = in_num_y;
  assign den_s[0]  = in_den;
  assign ctx_s[0]  = in_ctx;
  assign vld_s[0]  = in_valid;

  genvar g;
  generate
    for (g = 0; g < CW; g++) begin : g_stage
      logic [CW:0] tx;
      logic [CW:0] ty;
      logic        gx;
      logic        gy;
      mag_t        remx_nxt;
      mag_t        remy_nxt;

      if (g > 0) begin : g_link
        assign remx_s[g] = remx_r[g];
        assign remy_s[g] = remy_r[g];
        assign nqx_s[g]  = nqx_r[g];
        assign nqy_s[g]  = nqy_r[g];
        assign den_s[g]  = den_r[g];
        assign ctx_s[g]  = ctx_r[g];
        assign vld_s[g]  = vld_r[g];
      end

      always_comb begin
        tx       = {remx_s[g], nqx_s[g][CW-1]};
        ty       = {remy_s[g], nqy_s[g][CW-1]};
        gx       = (tx >= {1'b0, den_s[g]});
        gy       = (ty >= {1'b0, den_s[g]});
        remx_nxt = gx ? CW'(tx - {1'b0, den_s[g]}) : tx[CW-1:0];
        remy_nxt = gy ? CW'(ty - {1'b0, den_s[g]}) : ty[CW-1:0];
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r[g+1] <= 1'b0;
        end else if (en) begin
          vld_r[g+1] <= vld_s[g];
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          remx_r[g+1] <= remx_nxt;
          remy_r[g+1] <= remy_nxt;
          nqx_r[g+1]  <= {nqx_s[g][CW-2:0], gx};
          nqy_r[g+1]  <= {nqy_s[g][CW-2:0], gy};
          den_r[g+1]  <= den_s[g];
          ctx_r[g+1]  <= ctx_s[g];
        end
      end
    end
  endgenerate

  assign out_valid = vld_r[CW];
  assign out_q_x   = nqx_r[CW];
  assign out_q_y   = nqy_r[CW];
  assign out_ctx   = ctx_r[CW];

endmodule

@@ hw/rtl/int2_vector_alu.sv @@
// top level of the 2d integer vector alu: operand stages, root, divide, result
//
//  channel | dir | handshake                  | payload
//  in_     | in  | in_tvalid / in_tready      | in_tdata: op, a_x, a_y, b_x, b_y, scalar_in
//  out_    | out | out_tvalid / out_tready    | out_tdata: res_x, res_y, res_scalar,
//          |     |                            |   compare_true, div_zero
//
// one word enters per cycle while the output is not held; every word passes through
// the 32 square root stages and the 32 divider stages
// reset clears only the valid bits, the pipeline is empty afterwards
// the whole pipeline advances when the output register is empty or taken;
// a held output freezes all stages, so nothing is lost or repeated
module int2_vector_alu (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // op[3:0], a_x[35:4], a_y[67:36], b_x[99:68], b_y[131:100], scalar_in[163:132]
  input  logic [167:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // res_x[31:0], res_y[63:32], res_scalar[95:64], compare_true[96], div_zero[97]
  output logic [103:0] out_tdata
);
  import ivalu_pkg::*;

  // global advance
  logic adv;
  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;

  // stage 0: capture operands, keep low component bits
  logic v0_r;
  ctx_t c0_r;
  ctx_t c0_nxt;

  always_comb begin
    c0_nxt    = '0;
    c0_nxt.op = in_tdata[3:0];
    c0_nxt.ax = CW'(in_tdata[4   +: FW]);
    c0_nxt.ay = CW'(in_tdata[36  +: FW]);
    c0_nxt.bx = CW'(in_tdata[68  +: FW]);
    c0_nxt.by = CW'(in_tdata[100 +: FW]);
    c0_nxt.s  = CW'(in_tdata[132 +: FW]);
  end

  // stage 1: products and squares
  logic                   v1_r;
  ctx_t                   c1_r;
  logic signed [2*CW-1:0] p0_r, p1_r;
  logic signed [2*CW-1:0] p0_nxt, p1_nxt;
  rad_t                   q0_r, q1_r;
  rad_t                   q0_nxt, q1_nxt;
  comp_t                  m0, m1;
  mag_t                   ux, uy;

  always_comb begin
    m0     = (c0_r.op == OP_MULS) ? c0_r.s : c0_r.bx;
    m1     = (c0_r.op == OP_MULS) ? c0_r.s : c0_r.by;
    // sign-extended operands, full signed product
    p0_nxt = (2*CW)'(c0_r.ax) * (2*CW)'(m0);
    p1_nxt = (2*CW)'(c0_r.ay) * (2*CW)'(m1);
    // magnitude of B for projection, of A otherwise
    ux     = abs_c((c0_r.op == OP_PROJ) ? c0_r.bx : c0_r.ax);
    uy     = abs_c((c0_r.op == OP_PROJ) ? c0_r.by : c0_r.ay);
    q0_nxt = rad_t'(ux) * rad_t'(ux);
    q1_nxt = rad_t'(uy) * rad_t'(uy);
  end

  // stage 2: simple results, dot product, sum of squares
  logic  v2_r;
  ctx_t  c2_r;
  ctx_t  c2_nxt;
  rad_t  rad2_r;
  logic  same;

  always_comb begin
    c2_nxt     = c1_r;
    c2_nxt.dot = CW'(p0_r) + CW'(p1_r);
    same       = (c1_r.ax == c1_r.bx) && (c1_r.ay == c1_r.by);
    case (c1_r.op) inside
      OP_ADD: begin
        c2_nxt.rx = c1_r.ax + c1_r.bx;
        c2_nxt.ry = c1_r.ay + c1_r.by;
      end
      OP_SUB: begin
        c2_nxt.rx = c1_r.ax - c1_r.bx;
        c2_nxt.ry = c1_r.ay - c1_r.by;
      end
      OP_ADDS: begin
        c2_nxt.rx = c1_r.ax + c1_r.s;
        c2_nxt.ry = c1_r.ay + c1_r.s;
      end
      OP_SUBS: begin
        c2_nxt.rx = c1_r.ax - c1_r.s;
        c2_nxt.ry = c1_r.ay - c1_r.s;
      end
      OP_MUL, OP_MULS: begin
        c2_nxt.rx = CW'(p0_r);
        c2_nxt.ry = CW'(p1_r);
      end
      OP_EQ:  c2_nxt.cmp = same;
      OP_NE:  c2_nxt.cmp = !same;
      OP_DOT: c2_nxt.rs  = CW'(p0_r) + CW'(p1_r);
      default: ;
    endcase
  end

  // square root
  logic sq_v;
  mag_t sq_root;
  ctx_t sq_ctx;

  ivalu_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (v2_r),
    .in_rad    (rad2_r),
    .in_ctx    (c2_r),
    .out_valid (sq_v),
    .out_root  (sq_root),
    .out_ctx   (sq_ctx)
  );

  // stage 3: magnitude, wrapped to a component
  logic  v3_r;
  ctx_t  c3_r;
  ctx_t  c3_nxt;
  comp_t m3_r;

  always_comb begin
    c3_nxt = sq_ctx;
    if (sq_ctx.op == OP_MAG) begin
      c3_nxt.rs = comp_t'(sq_root);
    end
  end

  // stage 4: squared magnitude for projection
  logic  v4_r;
  ctx_t  c4_r;
  comp_t m4_r;
  comp_t mm4_r;
  comp_t mm4_nxt;

  assign mm4_nxt = CW'(m3_r * m3_r);

  // stage 5: divider operands as magnitudes plus quotient signs
  logic  v5_r;
  ctx_t  c5_r;
  ctx_t  c5_nxt;
  mag_t  nx5_r, ny5_r, den5_r;
  comp_t nx, ny, den;

  always_comb begin
    c5_nxt = c4_r;
    nx     = c4_r.ax;
    ny     = c4_r.ay;
    den    = c4_r.s;
    case (c4_r.op)
      OP_NORM: den = m4_r;
      OP_PROJ: begin
        nx  = c4_r.dot;
        ny  = '0;
        den = mm4_r;
      end
      default: ;
    endcase
    c5_nxt.flag  = (den == '0);
    c5_nxt.neg_x = nx[CW-1] ^ den[CW-1];
    c5_nxt.neg_y = ny[CW-1] ^ den[CW-1];
  end

  // divider
  logic dv_v;
  mag_t dv_qx, dv_qy;
  ctx_t dv_ctx;

  ivalu_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_valid  (v5_r),
    .in_num_x  (nx5_r),
    .in_num_y  (ny5_r),
    .in_den    (den5_r),
    .in_ctx    (c5_r),
    .out_valid (dv_v),
    .out_q_x   (dv_qx),
    .out_q_y   (dv_qy),
    .out_ctx   (dv_ctx)
  );

  // stage 6: signed quotients, truncated toward zero
  logic  v6_r;
  ctx_t  c6_r;
  comp_t qx6_r, qy6_r;

  // output register: projection scaling and final select
  logic  out_valid_r;
  comp_t rx_r, ry_r, rs_r;
  logic  cmp_r, dz_r;
  comp_t rx_nxt, ry_nxt, rs_nxt;
  logic  cmp_nxt, dz_nxt;
  comp_t px, py;

  always_comb begin
    px      = CW'(qx6_r * c6_r.bx);
    py      = CW'(qx6_r * c6_r.by);
    rx_nxt  = c6_r.rx;
    ry_nxt  = c6_r.ry;
    rs_nxt  = c6_r.rs;
    cmp_nxt = c6_r.cmp;
    dz_nxt  = 1'b0;
    case (c6_r.op)
      OP_DIVS: begin
        dz_nxt = c6_r.flag;
        rx_nxt = c6_r.flag ? '0 : qx6_r;
        ry_nxt = c6_r.flag ? '0 : qy6_r;
      end
      OP_NORM: begin
        // zero magnitude leaves A as it is
        rx_nxt = c6_r.flag ? c6_r.ax : qx6_r;
        ry_nxt = c6_r.flag ? c6_r.ay : qy6_r;
      end
      OP_PROJ: begin
        dz_nxt = c6_r.flag;
        rx_nxt = c6_r.flag ? '0 : px;
        ry_nxt = c6_r.flag ? '0 : py;
      end
      default: ;
    endcase
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r        <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      v5_r        <= 1'b0;
      v6_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v0_r        <= in_tvalid;
      v1_r        <= v0_r;
      v2_r        <= v1_r;
      v3_r        <= sq_v;
      v4_r        <= v3_r;
      v5_r        <= v4_r;
      v6_r        <= dv_v;
      out_valid_r <= v6_r;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (adv) begin
      c0_r   <= c0_nxt;
      c1_r   <= c0_r;
      p0_r   <= p0_nxt;
      p1_r   <= p1_nxt;
      q0_r   <= q0_nxt;
      q1_r   <= q1_nxt;
      c2_r   <= c2_nxt;
      rad2_r <= q0_r + q1_r;
      c3_r   <= c3_nxt;
      m3_r   <= comp_t'(sq_root);
      c4_r   <= c3_r;
      m4_r   <= m3_r;
      mm4_r  <= mm4_nxt;
      c5_r   <= c5_nxt;
      nx5_r  <= abs_c(nx);
      ny5_r  <= abs_c(ny);
      den5_r <= abs_c(den);
      c6_r   <= dv_ctx;
      qx6_r  <= dv_ctx.neg_x ? -comp_t'(dv_qx) : comp_t'(dv_qx);
      qy6_r  <= dv_ctx.neg_y ? -comp_t'(dv_qy) : comp_t'(dv_qy);
      rx_r   <= rx_nxt;
      ry_r   <= ry_nxt;
      rs_r   <= rs_nxt;
      cmp_r  <= cmp_nxt;
      dz_r   <= dz_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, dz_r, cmp_r, FW'(rs_r), FW'(ry_r), FW'(rx_r)};

  // a zero divisor clears every other result field
  a_dz_clears: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && dz_r |-> rx_r == '0 && ry_r == '0 && rs_r == '0 && !cmp_r)
    else $error("div_zero word carries nonzero results");

  // comparison and divide flags come from disjoint operations
  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(cmp_r && dz_r))
    else $error("compare_true and div_zero both set");

  // pipeline drains on reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && !v0_r && !v6_r)
    else $error("valid bits survive reset");

  // a frozen pipeline keeps the valid bits of stage 0 and stage 6
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(v0_r) && $stable(v6_r))
    else $error("stage valid changed during stall");

endmodule
